### hdl/rrfl_pkg.sv
package rrfl_pkg;

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_SOURCE = 2'd0;
   localparam logic [1:0] REQ_RENAME = 2'd1;
   localparam logic [1:0] REQ_FLAG   = 2'd2;
   localparam logic [1:0] REQ_QUERY  = 2'd3;

   typedef struct packed {
      logic [1:0] req_type;
      logic [4:0] arch_reg;
   } req_item_type;

   typedef struct packed {
      logic [4:0] phys_tag;
      logic       error;
   } rsp_item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
   } ctrl_cmd_type;

endpackage

### hdl/rrfl_ctrl.sv
module rrfl_ctrl import rrfl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_strobe,
   output ctrl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       strobe_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.lookup  = 1'b0;
      cmd.update  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.update;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

### hdl/rrfl_dpath.sv
module rrfl_dpath import rrfl_pkg::*; #(
   parameter int ARCH_REGS  = 16,
   parameter int PHYS_REGS  = 32,
   parameter int FLAG_TAGS  = 16,
   parameter int FREE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   input  req_item_type req_item,
   output rsp_item_type rsp_item
);

   localparam int AW = $clog2(ARCH_REGS);
   localparam int TW = $clog2(PHYS_REGS);
   localparam int FW = $clog2(FLAG_TAGS);
   localparam int DW = $clog2(FREE_DEPTH);

   localparam int REG_SPAN   = (PHYS_REGS > ARCH_REGS) ? PHYS_REGS - ARCH_REGS : 0;
   localparam int REG_COUNT  = (REG_SPAN > FREE_DEPTH) ? FREE_DEPTH : REG_SPAN;
   localparam int FLAG_COUNT = (FLAG_TAGS - 1 > FREE_DEPTH) ? FREE_DEPTH : FLAG_TAGS - 1;
   localparam int REG_TAIL0  = REG_COUNT % FREE_DEPTH;
   localparam int FLAG_TAIL0 = FLAG_COUNT % FREE_DEPTH;
   localparam bit REG_AVAIL  = (REG_COUNT > 0);
   localparam bit FLAG_AVAIL = (FLAG_COUNT > 0);

   req_item_type   req_ff;
   rsp_item_type   rsp_ff;

   logic [TW-1:0]        map_mem [ARCH_REGS];
   logic [ARCH_REGS-1:0] map_valid_ff;
   logic [TW-1:0]        map_rd_ff;
   logic                 map_hit_ff;

   logic [TW-1:0] reg_store [FREE_DEPTH];
   logic [TW-1:0] reg_rd_ff;
   logic [DW-1:0] reg_head_ff, reg_head_in;
   logic [DW-1:0] reg_tail_ff, reg_tail_in;
   logic          reg_lap_ff, reg_lap_in;

   logic [FW-1:0] flag_store [FREE_DEPTH];
   logic [FW-1:0] flag_rd_ff;
   logic [DW-1:0] flag_head_ff, flag_head_in;
   logic [DW-1:0] flag_tail_ff, flag_tail_in;
   logic          flag_lap_ff, flag_lap_in;
   logic [FW-1:0] flag_tag_ff, flag_tag_in;

   logic [AW+4:0] arch_ext;
   logic [AW-1:0] arch_idx;
   logic          arch_ok;

   logic [TW-1:0] old_map;
   logic [TW-1:0] reg_pop;
   logic [FW-1:0] flag_pop;
   logic [TW+4:0] old_ext, reg_pop_ext;
   logic [FW+4:0] flag_pop_ext, flag_tag_ext;

   logic          map_we, reg_we, flag_we;
   logic [4:0]    tag5;
   logic          err;

   function automatic logic [DW-1:0] next_ptr(input logic [DW-1:0] p);
      next_ptr = (p == DW'(FREE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign arch_ext = {{AW{1'b0}}, req_ff.arch_reg};
   assign arch_idx = arch_ext[AW-1:0];
   assign arch_ok  = (arch_ext < (AW+5)'(ARCH_REGS));

   // An entry never written since reset still holds its reset mapping.
   assign old_map = map_hit_ff ? map_rd_ff :
                    ((32'(arch_idx) < PHYS_REGS) ? TW'(arch_idx) : '0);

   // On the first lap of the head, the entries filled at reset have not been
   // overwritten yet; their contents follow from the index alone.
   assign reg_pop  = (reg_lap_ff && ({1'b0, reg_head_ff} < (DW+1)'(REG_COUNT))) ?
                     TW'(32'(ARCH_REGS) + 32'(reg_head_ff)) : reg_rd_ff;
   assign flag_pop = (flag_lap_ff && ({1'b0, flag_head_ff} < (DW+1)'(FLAG_COUNT))) ?
                     FW'(32'(flag_head_ff) + 32'd1) : flag_rd_ff;

   assign old_ext      = {5'b0, old_map};
   assign reg_pop_ext  = {5'b0, reg_pop};
   assign flag_pop_ext = {5'b0, flag_pop};
   assign flag_tag_ext = {5'b0, flag_tag_ff};

   always_comb begin
      map_we       = 1'b0;
      reg_we       = 1'b0;
      flag_we      = 1'b0;
      reg_head_in  = reg_head_ff;
      reg_tail_in  = reg_tail_ff;
      reg_lap_in   = reg_lap_ff;
      flag_head_in = flag_head_ff;
      flag_tail_in = flag_tail_ff;
      flag_lap_in  = flag_lap_ff;
      flag_tag_in  = flag_tag_ff;
      tag5         = '0;
      err          = 1'b0;
      unique case (req_ff.req_type)
         REQ_SOURCE: begin
            if (arch_ok) begin
               tag5 = old_ext[4:0];
            end else begin
               err = 1'b1;
            end
         end
         REQ_RENAME: begin
            if (arch_ok && REG_AVAIL) begin
               map_we      = 1'b1;
               reg_we      = 1'b1;
               reg_head_in = next_ptr(reg_head_ff);
               reg_tail_in = next_ptr(reg_tail_ff);
               if (reg_head_ff == DW'(FREE_DEPTH - 1)) begin
                  reg_lap_in = 1'b0;
               end
               tag5 = reg_pop_ext[4:0];
            end else begin
               err = 1'b1;
            end
         end
         REQ_FLAG: begin
            if (FLAG_AVAIL) begin
               flag_we      = 1'b1;
               flag_tag_in  = flag_pop;
               flag_head_in = next_ptr(flag_head_ff);
               flag_tail_in = next_ptr(flag_tail_ff);
               if (flag_head_ff == DW'(FREE_DEPTH - 1)) begin
                  flag_lap_in = 1'b0;
               end
               tag5 = flag_pop_ext[4:0];
            end else begin
               err = 1'b1;
            end
         end
         REQ_QUERY: begin
            tag5 = flag_tag_ext[4:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
         reg_head_ff  <= '0;
         reg_tail_ff  <= DW'(REG_TAIL0);
         reg_lap_ff   <= 1'b1;
         flag_head_ff <= '0;
         flag_tail_ff <= DW'(FLAG_TAIL0);
         flag_lap_ff  <= 1'b1;
         flag_tag_ff  <= '0;
      end else if (cmd.update) begin
         if (map_we) begin
            map_valid_ff[arch_idx] <= 1'b1;
         end
         reg_head_ff  <= reg_head_in;
         reg_tail_ff  <= reg_tail_in;
         reg_lap_ff   <= reg_lap_in;
         flag_head_ff <= flag_head_in;
         flag_tail_ff <= flag_tail_in;
         flag_lap_ff  <= flag_lap_in;
         flag_tag_ff  <= flag_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_ff <= '0;
      end else if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.lookup) begin
         map_rd_ff  <= map_mem[arch_idx];
         map_hit_ff <= map_valid_ff[arch_idx];
         reg_rd_ff  <= reg_store[reg_head_ff];
         flag_rd_ff <= flag_store[flag_head_ff];
      end
      if (cmd.update) begin
         rsp_ff.phys_tag <= tag5;
         rsp_ff.error    <= err;
         if (map_we) begin
            map_mem[arch_idx] <= reg_pop;
         end
         if (reg_we) begin
            reg_store[reg_tail_ff] <= old_map;
         end
         if (flag_we) begin
            flag_store[flag_tail_ff] <= flag_tag_ff;
         end
      end
   end

   assign rsp_item = rsp_ff;

endmodule

### hdl/register_rename_free_list.sv
// Channel   Ports                         Direction  Accepted when
// request   start, busy, req_item         in         start high and busy low at a clock edge
// result    rsp_strobe, rsp_item          out        the edge that ends the strobe cycle
//
// Each request is captured, then the map table and both free-list stores are
// read through registers, and then the result is computed and the tables are
// written back. The single read port of each store is why the reads take a
// step of their own. busy stays high through the lookup and update states after
// acceptance, and the result shows for one cycle with rsp_strobe in the cycle
// where a new request may already be accepted. Synchronous reset returns the
// map to identity, the flag tag to zero and both free lists to their initial
// contents without a clearing pass: valid bits cover the map and a first-lap
// flag covers each free list. The receiver cannot stall, so nothing holds results back.
module register_rename_free_list import rrfl_pkg::*; #(
   parameter int ARCH_REGS  = 16,
   parameter int PHYS_REGS  = 32,
   parameter int FLAG_TAGS  = 16,
   parameter int FREE_DEPTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   // Commands from the controller step the datapath through capture, lookup
   // and update for each request.
   ctrl_cmd_type cmd;

   rrfl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   // The datapath holds the map table, the flag tag and both circular free
   // lists; a rename or flag request pops the head of its list and pushes the
   // displaced tag at the tail in the same update, so each list keeps a constant occupancy.
   rrfl_dpath #(
      .ARCH_REGS  (ARCH_REGS),
      .PHYS_REGS  (PHYS_REGS),
      .FLAG_TAGS  (FLAG_TAGS),
      .FREE_DEPTH (FREE_DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   // A result is shown only while the block is ready for the next request.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // An accepted request produces its result once the controller has passed through lookup and update.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("result missing after accepted request");

   // An accepted request holds off the next one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after acceptance");

   // An error result never carries a tag.
   a_error_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.error) |-> (rsp_item.phys_tag == 5'd0))
      else $error("error result with nonzero tag");

endmodule
